>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Bodies vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: expression not true");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication not true");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/upd_pkg.sv
`default_nettype none

package upd_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PCT  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_UNI  = 2'd3
  } mode_t;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int unsigned RUN_MAX = 4;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
  } utf8_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] code);
    utf8_t u;
    u.bytes = '0;
    u.count = 2'd0;
    if (code < 16'h0080) begin
      u.bytes[0] = {1'b0, code[6:0]};
      u.count    = 2'd1;
    end else if (code < 16'h0800) begin
      u.bytes[0] = {3'b110, code[10:6]};
      u.bytes[1] = {2'b10, code[5:0]};
      u.count    = 2'd2;
    end else if (code >= 16'hD800 && code < 16'hE000) begin
      u.count = 2'd0;
    end else begin
      u.bytes[0] = {4'b1110, code[15:12]};
      u.bytes[1] = {2'b10, code[11:6]};
      u.bytes[2] = {2'b10, code[5:0]};
      u.count    = 2'd3;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

>>> rtl/url_percent_decoder_utf8.sv
// URL percent decoder with %u escapes emitted as UTF-8. Each accepted
// character updates the escape state in the same cycle and loads its zero to
// four decoded bytes into a run register; the run then leaves on the output
// channel one byte per cycle while out_ready is high, last_of_run marking its
// final byte. An item yielding at most one byte sustains one item per cycle
// while out_ready is high; one yielding more holds off the next transfer until
// the run register drains through the single output port. Items yielding no
// bytes (a '%' opening an escape, a digit not closing one) hold off nothing.
// A new transfer is taken only when the run register is empty or its last
// byte leaves in the same cycle, so a stalled output stalls the input as well.
`default_nettype none

`include "assert_macros.svh"

module url_percent_decoder_utf8 (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire upd_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output upd_pkg::out_item_t     out_data
);

  upd_pkg::mode_t mode, mode_next;
  logic [15:0]    acc, acc_next;
  logic [2:0]     dcnt, dcnt_next;

  logic [3:0][7:0] run, run_next;
  logic [2:0]      cnt, cnt_next;

  logic [3:0][7:0] res_bytes;
  logic [2:0]      res_n;

  upd_pkg::hex_t  hex;
  upd_pkg::utf8_t flush;
  logic [1:0]     flush_n;
  logic [2:0][7:0] flush_bytes;
  logic           plain_en;
  logic [7:0]     plain_byte;
  logic [15:0]    acc_shift;
  logic           in_xfer, out_xfer;

  assign hex       = upd_pkg::hex_decode(in_data.char_in);
  assign acc_shift = {acc[11:0], hex.value};
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign in_ready  = (cnt == 3'd0) || (cnt == 3'd1 && out_ready);
  assign out_valid = (cnt != 3'd0);
  assign out_data.byte_out    = run[0];
  assign out_data.last_of_run = (cnt == 3'd1);

  // Next escape state.
  always_comb begin
    mode_next = upd_pkg::MODE_IDLE;
    acc_next  = 16'h0000;
    dcnt_next = 3'd0;
    if (!in_data.end_marker) begin
      unique case (mode)
        upd_pkg::MODE_IDLE: begin
          if (in_data.char_in == upd_pkg::CHAR_PCT) mode_next = upd_pkg::MODE_PCT;
        end
        upd_pkg::MODE_PCT: begin
          if (in_data.char_in == upd_pkg::CHAR_PCT) begin
            mode_next = upd_pkg::MODE_IDLE;
          end else if (in_data.char_in == upd_pkg::CHAR_U) begin
            mode_next = upd_pkg::MODE_UNI;
          end else if (hex.valid) begin
            mode_next = upd_pkg::MODE_HEX;
            acc_next  = {12'h000, hex.value};
            dcnt_next = 3'd1;
          end
        end
        upd_pkg::MODE_HEX: begin
          if (!hex.valid && in_data.char_in == upd_pkg::CHAR_PCT) begin
            mode_next = upd_pkg::MODE_PCT;
          end
        end
        upd_pkg::MODE_UNI: begin
          if (hex.valid) begin
            if (dcnt != 3'd3) begin
              mode_next = upd_pkg::MODE_UNI;
              acc_next  = acc_shift;
              dcnt_next = dcnt + 3'd1;
            end
          end else if (in_data.char_in == upd_pkg::CHAR_PCT) begin
            mode_next = upd_pkg::MODE_PCT;
          end
        end
        default: mode_next = upd_pkg::MODE_IDLE;
      endcase
    end
  end

  // Bytes produced by this item: flushed escape first, then the character.
  always_comb begin
    flush       = upd_pkg::utf8_encode(acc);
    flush_n     = 2'd0;
    flush_bytes = '0;
    plain_en    = 1'b0;
    if (in_data.end_marker) begin
      if (mode == upd_pkg::MODE_HEX) begin
        flush_bytes[0] = acc[7:0];
        flush_n        = 2'd1;
      end else if (mode == upd_pkg::MODE_UNI) begin
        flush_bytes = flush.bytes;
        flush_n     = flush.count;
      end
    end else begin
      unique case (mode)
        upd_pkg::MODE_IDLE: plain_en = 1'b1;
        upd_pkg::MODE_PCT: begin
          if (in_data.char_in == upd_pkg::CHAR_PCT) begin
            flush_bytes[0] = upd_pkg::CHAR_PCT;
            flush_n        = 2'd1;
          end else if (in_data.char_in != upd_pkg::CHAR_U && !hex.valid) begin
            flush_bytes[0] = 8'h00;
            flush_n        = 2'd1;
            plain_en       = 1'b1;
          end
        end
        upd_pkg::MODE_HEX: begin
          flush_n = 2'd1;
          if (hex.valid) begin
            flush_bytes[0] = {acc[3:0], hex.value};
          end else begin
            flush_bytes[0] = acc[7:0];
            plain_en       = 1'b1;
          end
        end
        upd_pkg::MODE_UNI: begin
          if (hex.valid) begin
            if (dcnt == 3'd3) begin
              flush       = upd_pkg::utf8_encode(acc_shift);
              flush_bytes = flush.bytes;
              flush_n     = flush.count;
            end
          end else begin
            flush_bytes = flush.bytes;
            flush_n     = flush.count;
            plain_en    = 1'b1;
          end
        end
        default: plain_en = 1'b0;
      endcase
      // drop the plain byte for a '%': it opens a new escape instead
      if (in_data.char_in == upd_pkg::CHAR_PCT) plain_en = 1'b0;
    end
  end

  always_comb begin
    plain_byte = in_data.char_in;
    if (in_data.char_in == upd_pkg::CHAR_PLUS) plain_byte = upd_pkg::CHAR_SPACE;
  end

  always_comb begin
    res_bytes = {8'h00, flush_bytes};
    if (plain_en) res_bytes[flush_n] = plain_byte;
    res_n = {1'b0, flush_n} + {2'b00, plain_en};
  end

  // Load a fresh run on an input transfer, else advance on an output transfer.
  always_comb begin
    run_next = run;
    cnt_next = cnt;
    if (in_xfer) begin
      run_next = res_bytes;
      cnt_next = res_n;
    end else if (out_xfer) begin
      run_next = {8'h00, run[3:1]};
      cnt_next = cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    run <= run_next;
    if (rst) begin
      mode <= upd_pkg::MODE_IDLE;
      acc  <= 16'h0000;
      dcnt <= 3'd0;
      cnt  <= 3'd0;
    end else begin
      cnt <= cnt_next;
      if (in_xfer) begin
        mode <= mode_next;
        acc  <= acc_next;
        dcnt <= dcnt_next;
      end
    end
  end

  `ASSERT_ALWAYS(a_run_bound, clk, rst, cnt <= 3'(upd_pkg::RUN_MAX))
  `ASSERT_IMPLIES(a_pct_clear, clk, rst, mode == upd_pkg::MODE_PCT, acc == 16'h0 && dcnt == 3'd0)
  `ASSERT_IMPLIES(a_hex_one, clk, rst, mode == upd_pkg::MODE_HEX, dcnt == 3'd1 && acc < 16'h10)
  `ASSERT_IMPLIES(a_uni_digits, clk, rst, mode == upd_pkg::MODE_UNI, dcnt < 3'd4)

endmodule

`default_nettype wire
